@@ rtl/core/aduc_pkg.sv @@
// package for the advertisement unique-address counter
// holds sizes, item types and the command type shared by front and back
// no dependencies
`default_nettype none

package aduc_pkg;

	localparam int SLOTS     = 64;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int FILL_W    = SLOT_W + 1;
	localparam int ADDR_W    = 48;
	localparam int CNT_W     = 32;
	localparam int STR_W     = 8;
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = 1;
	localparam int CMD_CNT_W = CMD_PTR_W + 1;

	typedef struct packed {
		logic [ADDR_W-1:0]       device_address;
		logic signed [STR_W-1:0] signal_strength;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]        total_seen;
		logic [CNT_W-1:0]        unique_seen;
		logic signed [STR_W-1:0] latest_strength;
		logic                    was_new;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]       device_address;
		logic signed [STR_W-1:0] signal_strength;
		logic [CNT_W-1:0]        total_seen;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/aduc_front.sv @@
// front end: accepts advertisements, counts them, queues commands
// depends on aduc_pkg
`default_nettype none

module aduc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire aduc_pkg::in_item_t advert,
	output logic                   cmd_valid,
	input  wire logic              cmd_pop,
	output aduc_pkg::cmd_t         cmd
);
	import aduc_pkg::*;

	cmd_t                 cmd_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic [CNT_W-1:0]     total_q;
	logic                 wr_en;
	logic                 rd_en;

	assign full      = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = cmd_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			total_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
				total_q  <= total_q + CNT_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

	// command payload, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cmd_q[wr_ptr_q].device_address  <= advert.device_address;
			cmd_q[wr_ptr_q].signal_strength <= advert.signal_strength;
			cmd_q[wr_ptr_q].total_seen      <= total_q + CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/aduc_back.sv @@
// back end: scans the address table, counts unique addresses, holds the result
// depends on aduc_pkg
`default_nettype none

module aduc_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_pop,
	input  wire aduc_pkg::cmd_t  cmd,
	output logic                 empty,
	input  wire logic            pop,
	output aduc_pkg::out_item_t  stats
);
	import aduc_pkg::*;

	logic [ADDR_W-1:0] addr_mem [SLOTS];

	back_state_t       state_q;
	cmd_t              cur_q;
	logic [FILL_W-1:0] filled_q;
	logic [FILL_W-1:0] issue_q;
	logic [FILL_W-1:0] fill_now;
	logic [ADDR_W-1:0] rd_data_s1;
	logic              rd_vld_s1;
	logic              rd_last_s1;
	logic              new_q;
	logic [CNT_W-1:0]  unique_q;
	logic [CNT_W-1:0]  unique_nxt;
	logic              out_vld_q;
	out_item_t         out_q;
	logic              issuing;
	logic              match;
	logic              scan_end;
	logic              out_free;
	logic              finish;
	logic              has_room;
	logic              wr_en;

	assign fill_now   = (unique_q < CNT_W'(SLOTS)) ? unique_q[FILL_W-1:0] : FILL_W'(SLOTS);
	assign issuing    = (state_q == ST_SCAN) && (issue_q < filled_q);
	assign match      = rd_vld_s1 && (rd_data_s1 == cur_q.device_address);
	assign scan_end   = match || (rd_vld_s1 && rd_last_s1);
	assign out_free   = !out_vld_q || pop;
	assign finish     = (state_q == ST_DONE) && out_free;
	assign has_room   = (unique_q < CNT_W'(SLOTS));
	assign wr_en      = finish && new_q && has_room;
	assign unique_nxt = unique_q + CNT_W'(new_q);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign empty      = !out_vld_q;
	assign stats      = out_q;

	// table read pipeline and write port
	always_ff @(posedge clk) begin
		if (issuing) begin
			rd_data_s1 <= addr_mem[issue_q[SLOT_W-1:0]];
		end
		if (wr_en) begin
			addr_mem[unique_q[SLOT_W-1:0]] <= cur_q.device_address;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			filled_q   <= '0;
			issue_q    <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			new_q      <= 1'b0;
			unique_q   <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (cmd_valid) begin
						filled_q <= fill_now;
						issue_q  <= '0;
						if (fill_now == '0) begin
							new_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						issue_q <= issue_q + FILL_W'(1);
					end
					rd_vld_s1  <= issuing && !scan_end;
					rd_last_s1 <= (issue_q == filled_q - FILL_W'(1));
					if (scan_end) begin
						new_q   <= !match;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					rd_vld_s1 <= 1'b0;
					if (out_free) begin
						unique_q <= unique_nxt;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			priority if (finish) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end else begin
				out_vld_q <= out_vld_q;
			end
		end
	end

	// command and result payload, no reset
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (finish) begin
			out_q.total_seen      <= cur_q.total_seen;
			out_q.unique_seen     <= unique_nxt;
			out_q.latest_strength <= cur_q.signal_strength;
			out_q.was_new         <= new_q;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/advert_unique_address_counter_unit.sv @@
// top level of the advertisement unique-address counter
// depends on aduc_pkg, aduc_front and aduc_back
`default_nettype none

// Each advertisement pushed in gives one result with the running total count,
// the unique count, its signal strength and a flag that tells whether its
// address matched none of the stored addresses. The front end takes a new
// advertisement whenever its two-entry command queue has room; the back end
// reads the stored addresses one per cycle from a single-port table, stops
// the scan early when an address matches and skips it with an empty table.
// A result waits in an output register until it is popped, while the next scan
// goes on. Addresses past the table size still count as unique but are not stored.
module advert_unique_address_counter_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire aduc_pkg::in_item_t advert,
	output logic                    empty,
	input  wire logic               pop,
	output aduc_pkg::out_item_t     stats
);
	import aduc_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	aduc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.advert    (advert),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	aduc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.empty     (empty),
		.pop       (pop),
		.stats     (stats)
	);

`ifndef NO_ASSERTIONS
	// an accepted transfer lands in the command queue
	a_push_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> cmd_valid)
		else $error("accepted advertisement missing from command queue");

	// a repeat can only be found once something was counted as unique
	a_repeat_needs_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !stats.was_new) |-> (stats.unique_seen != '0))
		else $error("repeat reported with zero unique count");

	// the back end never takes a command from an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for advert_unique_address_counter_unit
// predicts running counts and the new-address flag per advertisement, checks each popped result
// depends on aduc_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;

	import aduc_pkg::*;

	localparam int IDLE_PCT     = 14;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 5000;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      pop    = 1'b0;
	in_item_t  advert = '0;
	logic      full;
	logic      empty;
	out_item_t stats;

	// predictor state
	logic [ADDR_W-1:0] seen_addr [SLOTS];
	logic [CNT_W-1:0]  model_total  = '0;
	logic [CNT_W-1:0]  model_unique = '0;

	out_item_t expected_stats [$];
	int        error_count = 0;
	int        stall_cycles = 0;
	logic      no_idle  = 1'b0;
	logic      hold_req = 1'b0;

	advert_unique_address_counter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.advert (advert),
		.empty  (empty),
		.pop    (pop),
		.stats  (stats)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic out_item_t predict_stats(input in_item_t adv);
		out_item_t res;
		int        filled;
		logic      hit;
		model_total = model_total + 1'b1;
		filled = (model_unique < SLOTS) ? int'(model_unique) : SLOTS;
		hit = 1'b0;
		for (int i = 0; i < filled; i++) begin
			if (seen_addr[i] == adv.device_address) hit = 1'b1;
		end
		if (!hit) begin
			if (model_unique < SLOTS) seen_addr[model_unique] = adv.device_address;
			model_unique = model_unique + 1'b1;
		end
		res.total_seen      = model_total;
		res.unique_seen     = model_unique;
		res.latest_strength = adv.signal_strength;
		res.was_new         = !hit;
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] fresh_address();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[ADDR_W-1:0];
	endfunction

	// mix of stored addresses, one-bit near misses of stored ones and fresh ones
	function automatic logic [ADDR_W-1:0] pick_address(input int known_pct, input int near_pct);
		int filled;
		int roll;
		int idx;
		filled = (model_unique < SLOTS) ? int'(model_unique) : SLOTS;
		roll = $urandom_range(99);
		if (filled == 0 || roll >= known_pct + near_pct) return fresh_address();
		idx = $urandom_range(filled - 1);
		if (roll < known_pct) return seen_addr[idx];
		return seen_addr[idx] ^ (48'h1 << $urandom_range(ADDR_W - 1));
	endfunction

	function automatic logic signed [STR_W-1:0] pick_strength();
		return STR_W'($urandom_range(255));
	endfunction

	task automatic send_advert(input logic [ADDR_W-1:0] addr, input logic signed [STR_W-1:0] rssi);
		in_item_t item;
		item.device_address  = addr;
		item.signal_strength = rssi;
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				push <= 1'b0;
				@(posedge clk);
			end
		end
		push   <= 1'b1;
		advert <= item;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_stats.push_back(predict_stats(item));
	endtask

	task automatic end_burst();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_extremes();
		send_advert(48'h0, -8'sd128);
		send_advert(48'hFFFF_FFFF_FFFF, 8'sd127);
		send_advert(48'h0, 8'sd0);
		send_advert(48'hFFFF_FFFF_FFFF, -8'sd1);
		send_advert(48'h5555_5555_5555, 8'sd1);
		send_advert(48'hAAAA_AAAA_AAAA, -8'sd2);
		send_advert(48'h0000_0000_0001, 8'sd127);
		send_advert(48'h8000_0000_0000, -8'sd128);
		send_advert(48'hFFFF_FFFF_FFFE, 8'sd64);
		send_advert(48'h5555_5555_5555, -8'sd64);
		send_advert(48'h8000_0000_0000, 8'sd0);
		end_burst();
	endtask

	task automatic test_table_fill();
		repeat (400) send_advert(pick_address(60, 25), pick_strength());
		while (model_unique < SLOTS) send_advert(fresh_address(), pick_strength());
		end_burst();
	endtask

	// table full: stored entries still match, misses count again each time
	task automatic test_full_table();
		logic [ADDR_W-1:0] extra;
		extra = fresh_address();
		send_advert(seen_addr[0], pick_strength());
		send_advert(seen_addr[SLOTS-1], pick_strength());
		send_advert(extra, pick_strength());
		send_advert(extra, pick_strength());
		send_advert(seen_addr[SLOTS/2], pick_strength());
		send_advert(extra ^ 48'h1, pick_strength());
		end_burst();
	endtask

	task automatic test_backpressure();
		hold_req <= 1'b1;
		repeat (40) send_advert(pick_address(70, 15), pick_strength());
		end_burst();
	endtask

	task automatic test_random_mix();
		repeat (600) send_advert(pick_address(75, 15), pick_strength());
		no_idle = 1'b1;
		repeat (300) send_advert(pick_address(75, 15), pick_strength());
		no_idle = 1'b0;
		repeat (450) send_advert(pick_address(75, 15), pick_strength());
		end_burst();
	endtask

	// result side
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req <= 1'b0;
			end else begin
				pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp;
		if (arst_n && pop && !empty) begin
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result transfer, actual %h", $time, stats);
				error_count++;
			end else begin
				exp = expected_stats.pop_front();
				if (stats.total_seen !== exp.total_seen) begin
					$display("%0t: total_seen expected %0d actual %0d",
						$time, exp.total_seen, stats.total_seen);
					error_count++;
				end
				if (stats.unique_seen !== exp.unique_seen) begin
					$display("%0t: unique_seen expected %0d actual %0d",
						$time, exp.unique_seen, stats.unique_seen);
					error_count++;
				end
				if (stats.latest_strength !== exp.latest_strength) begin
					$display("%0t: latest_strength expected %0d actual %0d",
						$time, exp.latest_strength, stats.latest_strength);
					error_count++;
				end
				if (stats.was_new !== exp.was_new) begin
					$display("%0t: was_new expected %b actual %b",
						$time, exp.was_new, stats.was_new);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_table_fill();
		test_full_table();
		test_backpressure();
		test_random_mix();
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
